[hw/rtl/svd_pkg.sv]
// Shared types, constants and the half-step coil table for the stepper valve drive.
// No dependencies; used by svd_step and stepper_valve_drive_top.
package svd_pkg;

	localparam int PHASE_COUNT = 8;
	localparam int PHASE_W     = $clog2(PHASE_COUNT);
	localparam int POS_W       = 16;
	localparam int OVS_W       = 8;
	localparam int COIL_W      = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// Item function codes.
	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_START = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRIVE_ENABLE   = 3'd0,
		REG_STEP_INTERVAL  = 3'd1,
		REG_NORMALLY_OPEN  = 3'd2,
		REG_OVERRUN_LIMIT  = 3'd3,
		REG_ORIGIN_MARGIN  = 3'd4,
		REG_HOME_OFFSET    = 3'd5
	} cfg_reg_t;

	// Reset values of the configuration registers.
	localparam logic             RST_DRIVE_ENABLE   = 1'b1;
	localparam logic [POS_W-1:0] RST_STEP_INTERVAL  = 16'd12;
	localparam logic             RST_NORMALLY_OPEN  = 1'b0;
	localparam logic [POS_W-1:0] RST_OVERRUN_LIMIT  = 16'd200;
	localparam logic [POS_W-1:0] RST_ORIGIN_MARGIN  = 16'd50;
	localparam logic [POS_W-1:0] RST_HOME_OFFSET    = 16'd480;

	localparam logic [COIL_W-1:0] COILS_OFF = 4'd0;

	typedef struct packed {
		logic             drive_enable;
		logic [POS_W-1:0] step_interval;
		logic             normally_open;
		logic [POS_W-1:0] overrun_limit;
		logic [POS_W-1:0] origin_margin;
		logic [POS_W-1:0] home_offset;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]   position;
		logic [POS_W-1:0]   goal;
		logic               moving;
		logic [POS_W-1:0]   overrun_count;
		logic [POS_W-1:0]   overrun_max;
		logic [OVS_W-1:0]   pending_backoff;
		logic [PHASE_W-1:0] phase;
		logic               seen_origin;
		logic [POS_W-1:0]   origin_position;
		logic [POS_W-1:0]   countdown;
		logic [COIL_W-1:0]  coils;
	} drive_state_t;

	// Drive state after reset: idle at zero, coils off, overrun limit at its default.
	localparam drive_state_t DRIVE_STATE_RST = '{
		position:        '0,
		goal:            '0,
		moving:          1'b0,
		overrun_count:   '0,
		overrun_max:     RST_OVERRUN_LIMIT,
		pending_backoff: '0,
		phase:           '0,
		seen_origin:     1'b0,
		origin_position: '0,
		countdown:       '0,
		coils:           COILS_OFF
	};

	// Half-step excitation: bit0 X1, bit1 Y1, bit2 X2, bit3 Y2.
	function automatic logic [COIL_W-1:0] half_step_coils(input logic [PHASE_W-1:0] ph);
		logic [COIL_W-1:0] c;
		case (ph)
			3'd0:    c = 4'd3;
			3'd1:    c = 4'd2;
			3'd2:    c = 4'd6;
			3'd3:    c = 4'd4;
			3'd4:    c = 4'd12;
			3'd5:    c = 4'd8;
			3'd6:    c = 4'd9;
			default: c = 4'd1;
		endcase
		return c;
	endfunction

endpackage

[hw/rtl/svd_step.sv]
// Next-state logic of the stepper valve drive for one tick or start item.
// Depends on svd_pkg for the state and configuration structs and the coil table.
module svd_step (
	input  svd_pkg::drive_state_t          cur,
	input  svd_pkg::cfg_t                  cfg,
	input  logic                           func,
	input  logic [svd_pkg::POS_W-1:0]      target_position,
	input  logic [svd_pkg::OVS_W-1:0]      open_overshoot,
	input  logic                           origin_sensor,
	output svd_pkg::drive_state_t          nxt
);

	logic [svd_pkg::POS_W-1:0]   cd_dec;
	logic [svd_pkg::POS_W-1:0]   pos_inc;
	logic [svd_pkg::POS_W-1:0]   pos_dec;
	logic [svd_pkg::POS_W-1:0]   limit_raw;
	logic [svd_pkg::POS_W-1:0]   limit_clamped;
	logic [svd_pkg::PHASE_W-1:0] phase_up;
	logic [svd_pkg::PHASE_W-1:0] phase_dn;
	logic                        service;

	// Shared arithmetic for one step.
	assign cd_dec        = (cur.countdown != '0) ? cur.countdown - 1'b1 : '0;
	assign pos_inc       = cur.position + 1'b1;
	assign pos_dec       = cur.position - 1'b1;
	assign limit_raw     = cur.origin_position - cfg.origin_margin;
	assign limit_clamped = (limit_raw > cfg.overrun_limit) ? cfg.overrun_limit : limit_raw;
	assign phase_up      = cur.phase + 1'b1;
	assign phase_dn      = cur.phase - 1'b1;
	assign service       = cfg.drive_enable && (cd_dec == '0);

	always_comb begin
		nxt = cur;
		if (func == svd_pkg::FUNC_START) begin
			// A start is ignored while moving or when already at the target.
			if (!cur.moving && cur.position != target_position) begin
				if (target_position == '0) begin
					nxt.overrun_count = '0;
					nxt.position      = cur.position + cfg.home_offset;
					nxt.goal          = '0;
				end else if (cur.position >= target_position) begin
					nxt.overrun_count   = '0;
					nxt.pending_backoff = '0;
					nxt.goal            = target_position;
				end else begin
					nxt.pending_backoff = open_overshoot;
					nxt.goal = target_position + {{(svd_pkg::POS_W-svd_pkg::OVS_W){1'b0}},
						open_overshoot};
				end
				nxt.moving    = 1'b1;
				nxt.countdown = cfg.step_interval;
			end
		end else begin
			nxt.countdown = cd_dec;
			if (service) begin
				nxt.countdown = cfg.step_interval;
				nxt.coils     = svd_pkg::COILS_OFF;
				if (cur.moving) begin
					if (cur.goal > cur.position) begin
						// Opening step; learn the origin and derive the overrun limit.
						nxt.position = pos_inc;
						nxt.phase    = cfg.normally_open ? phase_dn : phase_up;
						if (origin_sensor) begin
							nxt.origin_position = pos_inc;
							nxt.seen_origin     = 1'b1;
						end else if (cur.seen_origin) begin
							nxt.overrun_max = limit_clamped;
						end
						nxt.coils = svd_pkg::half_step_coils(nxt.phase);
					end else if (cur.goal < cur.position) begin
						if (origin_sensor && cur.overrun_count >= cur.overrun_max) begin
							// Overrun limit reached on the sensor: stop at zero.
							nxt.goal          = '0;
							nxt.position      = '0;
							nxt.overrun_count = '0;
							nxt.moving        = 1'b0;
						end else begin
							// Closing step; position is above the goal, so it is nonzero.
							if (origin_sensor) begin
								nxt.overrun_count = cur.overrun_count + 1'b1;
							end
							nxt.position = pos_dec;
							nxt.phase    = cfg.normally_open ? phase_up : phase_dn;
							if (pos_dec == '0) begin
								nxt.goal          = '0;
								nxt.overrun_count = '0;
								nxt.moving        = 1'b0;
							end else begin
								nxt.coils = svd_pkg::half_step_coils(nxt.phase);
							end
						end
					end else if (cur.goal != '0 && cur.pending_backoff != '0) begin
						// At the overshoot point: back off toward the real target.
						nxt.goal = cur.goal - {{(svd_pkg::POS_W-svd_pkg::OVS_W){1'b0}},
							cur.pending_backoff};
						nxt.pending_backoff = '0;
					end else begin
						nxt.overrun_count = '0;
						nxt.moving        = 1'b0;
					end
				end
			end
		end
	end

endmodule

[hw/rtl/stepper_valve_drive_top.sv]
// Top level of the stepper valve drive: configuration registers, drive state and result register.
// Depends on svd_pkg and svd_step.
//
// Usage: items arrive on the in_valid/in_ready channel. func selects a tick (one 50 us
// interval, with origin_sensor sampled) or a start command (target_position and
// open_overshoot). Every item yields exactly one result on out_valid/out_ready: the
// coil pattern, the running flag and the position after that item.
// A result is shown the cycle after its item transfers.
// One item is taken per cycle while in_ready is high; the whole update is one pass of svd_step
// between the state registers and the result register.
// in_ready is high whenever the result register is empty or being emptied in the same
// cycle, so a stalled receiver holds off new items only while a result waits.
// Registers are written through cfg_write, cfg_index and cfg_data at any edge; indexes
// beyond the list are ignored.
// Reset clears the drive state (coils off, position zero), loads the default register
// values and empties the result register. No clearing pass is needed.
module stepper_valve_drive_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [svd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [svd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [svd_pkg::POS_W-1:0]         target_position,
	input  logic [svd_pkg::OVS_W-1:0]         open_overshoot,
	input  logic                              origin_sensor,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [svd_pkg::COIL_W-1:0]        coil_pattern,
	output logic                              running,
	output logic [svd_pkg::POS_W-1:0]         current_position
);

	svd_pkg::cfg_t         cfg_q;
	svd_pkg::drive_state_t state_q;
	svd_pkg::drive_state_t state_nxt;
	logic                  out_valid_q;
	logic [svd_pkg::COIL_W-1:0] coil_q;
	logic                  running_q;
	logic [svd_pkg::POS_W-1:0]  position_q;
	logic                  in_xfer;

	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_enable   <= svd_pkg::RST_DRIVE_ENABLE;
			cfg_q.step_interval  <= svd_pkg::RST_STEP_INTERVAL;
			cfg_q.normally_open  <= svd_pkg::RST_NORMALLY_OPEN;
			cfg_q.overrun_limit  <= svd_pkg::RST_OVERRUN_LIMIT;
			cfg_q.origin_margin  <= svd_pkg::RST_ORIGIN_MARGIN;
			cfg_q.home_offset    <= svd_pkg::RST_HOME_OFFSET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				svd_pkg::REG_DRIVE_ENABLE:   cfg_q.drive_enable   <= cfg_data[0];
				svd_pkg::REG_STEP_INTERVAL:  cfg_q.step_interval  <= cfg_data;
				svd_pkg::REG_NORMALLY_OPEN:  cfg_q.normally_open  <= cfg_data[0];
				svd_pkg::REG_OVERRUN_LIMIT:  cfg_q.overrun_limit  <= cfg_data;
				svd_pkg::REG_ORIGIN_MARGIN:  cfg_q.origin_margin  <= cfg_data;
				svd_pkg::REG_HOME_OFFSET:    cfg_q.home_offset    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next-state logic for the item being transferred.
	svd_step u_step (
		.cur             (state_q),
		.cfg             (cfg_q),
		.func            (func),
		.target_position (target_position),
		.open_overshoot  (open_overshoot),
		.origin_sensor   (origin_sensor),
		.nxt             (state_nxt)
	);

	// Drive state, updated once per transferred item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svd_pkg::DRIVE_STATE_RST;
		end else if (in_xfer) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			coil_q     <= state_nxt.coils;
			running_q  <= state_nxt.moving;
			position_q <= state_nxt.position;
		end
	end

	assign out_valid        = out_valid_q;
	assign coil_pattern     = coil_q;
	assign running          = running_q;
	assign current_position = position_q;

	// The coils are only energized while a move is in progress.
	a_coils_off_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.moving |-> state_q.coils == svd_pkg::COILS_OFF)
		else $error("coils energized with no move in progress");

	// Every transferred item produces a result in the next cycle.
	a_result_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> out_valid_q)
		else $error("transferred item produced no result");

	// The phase only moves when an item is transferred.
	a_phase_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_xfer |=> $stable(state_q.phase))
		else $error("phase changed without an item");

	// The result register matches the drive state while it is full.
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (running_q == state_q.moving && position_q == state_q.position))
		else $error("result register out of step with drive state");

endmodule
